>>> rtl/sv48ptw_pkg.sv
// ----------------------------------------------------------------------------
// sv48ptw_pkg
// Shared types and constants for the Sv48 page table map and walk unit.
// ----------------------------------------------------------------------------
package sv48ptw_pkg;

  localparam int unsigned IdxW   = 9;
  localparam int unsigned FlagW  = 8;
  localparam int unsigned VaW    = 48;
  localparam int unsigned PaW    = 56;
  localparam int unsigned PageW  = 12;
  localparam int unsigned PpnW   = PaW - PageW;
  localparam int unsigned PpnLsb = 10;
  localparam int unsigned EntryW = PpnW + PpnLsb;
  localparam int unsigned VpnW   = VaW - PageW;

  localparam logic MODE_MAP   = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_UNMAPPED = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  typedef logic [EntryW-1:0] entry_t;

endpackage

>>> rtl/sv48_page_table_map_and_walk_unit.sv
// ----------------------------------------------------------------------------
// sv48_page_table_map_and_walk_unit
// Four-level Sv48 page table map and translate over a local table store.
// ----------------------------------------------------------------------------
//  channel   | ports                                            | handshake
//  request   | mode_i virtual_addr_i physical_addr_i page_flags_i | start & !busy
//  result    | physical_page_o status_o                         | done_o pulse
//
//  After reset the store is cleared, one entry per cycle, all TABLE_COUNT*512
//  entries, with busy high. Each level of a walk is a read state and then an
//  evaluate state on the single table store port; a map writes the leaf in
//  its level 0 read state. A done state then presents the result. Failures
//  end early. done_o is high for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sv48_page_table_map_and_walk_unit
  import sv48ptw_pkg::*;
#(
  parameter int unsigned TABLE_COUNT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              mode_i,
  input  logic [VaW-1:0]    virtual_addr_i,
  input  logic [PaW-1:0]    physical_addr_i,
  input  logic [FlagW-1:0]  page_flags_i,
  output logic              done_o,
  output logic [PaW-1:0]    physical_page_o,
  output logic [1:0]        status_o
);

  localparam int unsigned Depth = TABLE_COUNT * (1 << IdxW);
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned TblW  = AddrW - IdxW;
  localparam int unsigned NftW  = $clog2(TABLE_COUNT + 1);

  state_e             state_q, state_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [NftW-1:0]    nft_q, nft_d;
  logic [TblW-1:0]    table_q, table_d;
  logic [1:0]         level_q, level_d;
  logic               mode_q;
  logic [VpnW-1:0]    vpn_q;
  logic [PpnW-1:0]    ppn_q;
  logic [FlagW-1:0]   flags_q;
  logic [PaW-1:0]     page_q, page_d;
  status_e            status_q, status_d;

  logic               ram_we;
  logic [AddrW-1:0]   ram_addr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  logic [IdxW-1:0]    idx;
  logic               entry_zero;
  logic               ptr_ok;
  logic               accept;

  assign accept = start && !busy;

  always_comb begin
    case (level_q)
      2'd3:    idx = vpn_q[3*IdxW +: IdxW];
      2'd2:    idx = vpn_q[2*IdxW +: IdxW];
      2'd1:    idx = vpn_q[IdxW +: IdxW];
      default: idx = vpn_q[0 +: IdxW];
    endcase
  end

  assign entry_zero = (ram_rdata == '0);
  assign ptr_ok     = (ram_rdata[EntryW-1:PpnLsb] < PpnW'(TABLE_COUNT));

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    nft_d     = nft_q;
    table_d   = table_q;
    level_d   = level_q;
    page_d    = page_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_addr  = {table_q, idx};
    ram_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          table_d  = '0;
          level_d  = 2'd3;
          page_d   = '0;
          status_d = STATUS_OK;
          state_d  = ST_READ;
        end
      end
      ST_READ: begin
        if (mode_q == MODE_MAP && level_q == 2'd0) begin
          ram_we    = 1'b1;
          ram_wdata = {ppn_q, (PpnLsb - FlagW)'(0), flags_q};
          state_d   = ST_DONE;
        end else begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (level_q == 2'd0) begin
          if (entry_zero) begin
            status_d = STATUS_UNMAPPED;
          end else begin
            page_d = {ram_rdata[EntryW-1:PpnLsb], PageW'(0)};
          end
          state_d = ST_DONE;
        end else if (entry_zero) begin
          if (mode_q == MODE_XLATE) begin
            status_d = STATUS_UNMAPPED;
            state_d  = ST_DONE;
          end else if (nft_q >= NftW'(TABLE_COUNT)) begin
            status_d = STATUS_FULL;
            state_d  = ST_DONE;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = (EntryW'(nft_q) << PpnLsb) | EntryW'(1);
            table_d   = nft_q[TblW-1:0];
            nft_d     = nft_q + 1'b1;
            level_d   = level_q - 2'd1;
            state_d   = ST_READ;
          end
        end else if (!ptr_ok) begin
          status_d = (mode_q == MODE_XLATE) ? STATUS_UNMAPPED : STATUS_FULL;
          state_d  = ST_DONE;
        end else begin
          table_d = ram_rdata[PpnLsb +: TblW];
          level_d = level_q - 2'd1;
          state_d = ST_READ;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      nft_q    <= NftW'(1);
      table_q  <= '0;
      level_q  <= 2'd3;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      nft_q    <= nft_d;
      table_q  <= table_d;
      level_q  <= level_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    if (accept) begin
      mode_q  <= mode_i;
      vpn_q   <= virtual_addr_i[VaW-1:PageW];
      ppn_q   <= physical_addr_i[PaW-1:PageW];
      flags_q <= page_flags_i;
    end
  end

  sv48ptw_ram #(
    .DATA_W (EntryW),
    .DEPTH  (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = (state_q == ST_DONE);
  assign physical_page_o = page_q;
  assign status_o        = status_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held longer than one cycle");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_READ && level_q == 2'd3 && table_q == '0))
    else $error("walk did not start at the root");

  a_nft_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nft_q >= NftW'(1)) && (nft_q <= NftW'(TABLE_COUNT)))
    else $error("free table counter out of range");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o != 2'd3))
    else $error("invalid status code");

  a_fail_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STATUS_OK) |-> (physical_page_o == '0))
    else $error("failed request returned a page");

endmodule

>>> rtl/sv48ptw_ram.sv
// ----------------------------------------------------------------------------
// sv48ptw_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sv48ptw_ram #(
  parameter int unsigned DATA_W = 64,
  parameter int unsigned DEPTH  = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Sv48 page table map and walk unit. A shadow
// copy of the table store predicts each map and translate request; results
// are checked in order, under varied sender gaps, up to store exhaustion.
// ----------------------------------------------------------------------------
module tb_top
  import sv48ptw_pkg::*;
();

  localparam int unsigned TABLE_COUNT    = 64;
  localparam int unsigned WATCHDOG_LIMIT = 150000;  // covers the store clear

  typedef struct packed {
    logic [PaW-1:0] page;
    status_e        status;
  } xlat_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             mode_i = MODE_MAP;
  logic [VaW-1:0]   virtual_addr_i = '0;
  logic [PaW-1:0]   physical_addr_i = '0;
  logic [FlagW-1:0] page_flags_i = '0;
  logic             done_o;
  logic [PaW-1:0]   physical_page_o;
  logic [1:0]       status_o;

  bit [EntryW-1:0]  shadow_pte [TABLE_COUNT << IdxW];
  int unsigned      next_table = 1;
  xlat_result_t     awaited[$];
  logic [VaW-1:0]   mapped_vas[$];
  logic [IdxW-1:0]  l3_pool[3];
  logic [IdxW-1:0]  l2_pool[3];
  logic [IdxW-1:0]  l1_pool[3];
  int unsigned      sender_idle_pct = 0;
  int unsigned      errors = 0;
  int unsigned      quiet_cycles = 0;

  sv48_page_table_map_and_walk_unit #(
    .TABLE_COUNT(TABLE_COUNT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .virtual_addr_i (virtual_addr_i),
    .physical_addr_i(physical_addr_i),
    .page_flags_i   (page_flags_i),
    .done_o         (done_o),
    .physical_page_o(physical_page_o),
    .status_o       (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int unsigned pte_slot(int unsigned tbl, logic [VaW-1:0] va, int lvl);
    return (tbl << IdxW) | va[PageW + IdxW*lvl +: IdxW];
  endfunction

  // Applies one request to the shadow store and returns what the unit must report.
  function automatic xlat_result_t walk_tables(logic m, logic [VaW-1:0] va,
                                               logic [PaW-1:0] pa, logic [FlagW-1:0] flags);
    xlat_result_t    r;
    bit [EntryW-1:0] e;
    int unsigned     tbl;
    int unsigned     s;
    r.page   = '0;
    r.status = STATUS_OK;
    tbl      = 0;
    for (int lvl = 3; lvl >= 1; lvl--) begin
      s = pte_slot(tbl, va, lvl);
      e = shadow_pte[s];
      if (e == '0) begin
        if (m == MODE_XLATE) begin
          r.status = STATUS_UNMAPPED;
          return r;
        end
        if (next_table >= TABLE_COUNT) begin
          r.status = STATUS_FULL;
          return r;
        end
        e = (EntryW'(next_table) << PpnLsb) | EntryW'(1);
        shadow_pte[s] = e;
        next_table++;
      end
      if ((e >> PpnLsb) >= TABLE_COUNT) begin
        r.status = (m == MODE_XLATE) ? STATUS_UNMAPPED : STATUS_FULL;
        return r;
      end
      tbl = int'(e >> PpnLsb);
    end
    s = pte_slot(tbl, va, 0);
    if (m == MODE_MAP) begin
      shadow_pte[s] = {pa[PaW-1:PageW], 2'b00, flags};
    end else if (shadow_pte[s] == '0) begin
      r.status = STATUS_UNMAPPED;
    end else begin
      r.page = {shadow_pte[s][EntryW-1:PpnLsb], {PageW{1'b0}}};
    end
    return r;
  endfunction

  // Number of tables a map of va would allocate.
  function automatic int tables_needed(logic [VaW-1:0] va);
    bit [EntryW-1:0] e;
    int unsigned     tbl;
    tbl = 0;
    for (int lvl = 3; lvl >= 1; lvl--) begin
      e = shadow_pte[pte_slot(tbl, va, lvl)];
      if (e == '0) return lvl;
      tbl = int'(e >> PpnLsb);
    end
    return 0;
  endfunction

  function automatic logic [VaW-1:0] pool_va();
    return {l3_pool[$urandom_range(2)], l2_pool[$urandom_range(2)],
            l1_pool[$urandom_range(2)], IdxW'($urandom()), PageW'($urandom())};
  endfunction

  task automatic send_request(input logic m, input logic [VaW-1:0] va,
                              input logic [PaW-1:0] pa, input logic [FlagW-1:0] flags);
    xlat_result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    mode_i          <= m;
    virtual_addr_i  <= va;
    physical_addr_i <= pa;
    page_flags_i    <= flags;
    do @(posedge clk_i); while (busy !== 1'b0);
    r = walk_tables(m, va, pa, flags);
    awaited.push_back(r);
    if (m == MODE_MAP && r.status == STATUS_OK) mapped_vas.push_back(va);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [VaW-1:0] va;
    sender_idle_pct = 0;
    send_request(MODE_XLATE, '0, '0, '0);                     // empty root
    send_request(MODE_MAP, '0, '0, '0);                       // all-zero leaf
    send_request(MODE_XLATE, '0, '1, '1);
    send_request(MODE_MAP, 48'h0000_0000_0fff, '1, 8'hff);    // remap
    send_request(MODE_XLATE, 48'h0000_0000_0fff, '0, '0);
    send_request(MODE_MAP, '1, 56'h00a5_5a5a_5a5a_5abc, 8'h00);  // V clear
    send_request(MODE_XLATE, '1, '0, '0);
    va = '0;
    va[47:39] = '1;
    send_request(MODE_XLATE, va, '0, '0);                     // missing level 2
    va = '0;
    va[29:21] = '1;
    send_request(MODE_XLATE, va, '0, '0);                     // missing level 1
    va = '0;
    va[20:12] = '1;
    send_request(MODE_XLATE, va, '0, '0);                     // missing leaf
    send_request(MODE_MAP, va, 56'h0000_0000_0000_0fff, 8'h01);
    send_request(MODE_XLATE, va, '0, '0);
    send_request(MODE_MAP, '1, '0, 8'h80);
    send_request(MODE_XLATE, 48'hffff_ffff_f000, '0, '0);
    send_request(MODE_MAP, 48'h0000_0000_1000, 56'h0080_0000_0000_1000, 8'hcf);
    send_request(MODE_XLATE, 48'h0000_0000_1abc, '0, '0);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
    logic [VaW-1:0] va;
    int unsigned    pick;
    sender_idle_pct = idle_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 8 && mapped_vas.size() != 0) begin
        va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
        va[PageW-1:0] = PageW'($urandom());
        send_request(MODE_MAP, va, PaW'(rand64()), FlagW'($urandom()));
      end else if (pick < 45) begin
        send_request(MODE_MAP, pool_va(), PaW'(rand64()), FlagW'($urandom()));
      end else if (pick < 80 && mapped_vas.size() != 0) begin
        va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
        va[PageW-1:0] = PageW'($urandom());
        send_request(MODE_XLATE, va, PaW'(rand64()), FlagW'($urandom()));
      end else if (pick < 90) begin
        send_request(MODE_XLATE, pool_va(), PaW'(rand64()), FlagW'($urandom()));
      end else if (pick < 95) begin
        va = pool_va();
        va[PageW + IdxW*$urandom_range(3, 1) +: IdxW] = IdxW'($urandom());
        send_request(MODE_XLATE, va, PaW'(rand64()), FlagW'($urandom()));
      end else begin
        send_request(MODE_XLATE, VaW'(rand64()), PaW'(rand64()), FlagW'($urandom()));
      end
    end
  endtask

  task automatic test_table_exhaustion();
    logic [VaW-1:0] va;
    logic [VaW-1:0] partial_va;
    sender_idle_pct = 10;
    // steer to exactly two free tables so a fresh path runs out halfway
    while (TABLE_COUNT - next_table > 2) begin
      if (TABLE_COUNT - next_table >= 5) begin
        do va = VaW'(rand64()); while (tables_needed(va) != 3);
      end else begin
        do begin
          va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
          va[29:21] = IdxW'($urandom());
        end while (tables_needed(va) != 1);
      end
      send_request(MODE_MAP, va, PaW'(rand64()), FlagW'($urandom()));
    end
    do partial_va = VaW'(rand64()); while (tables_needed(partial_va) != 3);
    send_request(MODE_MAP, partial_va, PaW'(rand64()), FlagW'($urandom()));
    send_request(MODE_XLATE, partial_va, '0, '0);
    do va = VaW'(rand64()); while (tables_needed(va) != 3);
    send_request(MODE_MAP, va, PaW'(rand64()), FlagW'($urandom()));
    do begin
      va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
      va[29:21] = IdxW'($urandom());
    end while (tables_needed(va) != 1);
    send_request(MODE_MAP, va, PaW'(rand64()), FlagW'($urandom()));
    va = mapped_vas[$urandom_range(mapped_vas.size() - 1)];
    va[20:12] = IdxW'($urandom());
    send_request(MODE_MAP, va, PaW'(rand64()), FlagW'($urandom()));
    send_request(MODE_XLATE, va, '0, '0);
    test_random_traffic(20, 30);
  endtask

  always @(posedge clk_i) begin : check_results
    xlat_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result page=%h status=%0d", $time, physical_page_o,
                 status_o);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (physical_page_o !== want.page) begin
          $display("%0t: physical_page expected %h actual %h", $time, want.page,
                   physical_page_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || done_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, awaited.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (l3_pool[i]) begin
      l3_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : IdxW'($urandom());
      l2_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : IdxW'($urandom());
      l1_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : IdxW'($urandom());
    end
    test_directed();
    wait_results_drained();
    test_random_traffic(19, 434);
    wait_results_drained();
    test_random_traffic(84, 433);
    wait_results_drained();
    test_random_traffic(0, 433);
    wait_results_drained();
    test_table_exhaustion();
    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (awaited.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sv48ptw_pkg.sv
rtl/sv48ptw_ram.sv
rtl/sv48_page_table_map_and_walk_unit.sv
tb/sv/tb_top.sv
